// ----- design/wsd_pkg.sv -----
// Package for the websocket frame deframer: word types, parse phases,
// result codes and opcode helpers. No dependencies.
package wsd_pkg;

    // Input word
    typedef struct packed {
        logic [7:0] rx_byte;
        logic       tx_closed;
    } t_in;

    // Result word
    typedef struct packed {
        logic [1:0] kind;
        logic       has_byte;
        logic [7:0] data_byte;
        logic [3:0] opcode;
        logic       last;
        logic [1:0] action;
        logic [2:0] error_code;
    } t_out;

    // Parse phases
    typedef enum logic [1:0] {
        PH_HEADER,
        PH_LENGTH,
        PH_EXT,
        PH_PAYLOAD
    } t_phase;

    // Result kinds
    localparam logic [1:0] KIND_BYTE  = 2'd0;
    localparam logic [1:0] KIND_END   = 2'd1;
    localparam logic [1:0] KIND_ERROR = 2'd2;

    // Actions
    localparam logic [1:0] ACT_NONE  = 2'd0;
    localparam logic [1:0] ACT_PONG  = 2'd1;
    localparam logic [1:0] ACT_CLOSE = 2'd2;
    localparam logic [1:0] ACT_ABORT = 2'd3;

    // Error codes
    localparam logic [2:0] ERR_NONE      = 3'd0;
    localparam logic [2:0] ERR_RSV       = 3'd1;
    localparam logic [2:0] ERR_MASKED    = 3'd2;
    localparam logic [2:0] ERR_UNKNOWN   = 3'd3;
    localparam logic [2:0] ERR_FRAGMENTS = 3'd4;

    // Opcodes
    localparam logic [3:0] OP_TEXT   = 4'h1;
    localparam logic [3:0] OP_BINARY = 4'h2;
    localparam logic [3:0] OP_CLOSE  = 4'h8;
    localparam logic [3:0] OP_PING   = 4'h9;
    localparam logic [3:0] OP_PONG   = 4'hA;

    // Length byte escapes
    localparam logic [6:0] LEN_EXT64 = 7'd127;
    localparam logic [6:0] LEN_EXT16 = 7'd126;
    localparam logic [3:0] EXT_BYTES64 = 4'd8;
    localparam logic [3:0] EXT_BYTES16 = 4'd2;

    // Opcodes whose payload bytes are passed on
    function automatic logic op_streams(input logic [3:0] op);
        return (op == OP_TEXT) || (op == OP_BINARY) || (op == OP_CLOSE) || (op == OP_PONG);
    endfunction

    function automatic logic op_known(input logic [3:0] op);
        return op_streams(op) || (op == OP_PING);
    endfunction

endpackage

// ----- design/wsd_parse.sv -----
// Frame parser: header, length, extended length and payload phases,
// fragment tracking and result generation. Depends on wsd_pkg.
module wsd_parse #(
    parameter int MAX_FRAGMENTS = 64
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_step,
    input  wsd_pkg::t_in  i_data,
    output logic          o_res_valid,
    output wsd_pkg::t_out o_res
);
    import wsd_pkg::*;

    t_phase      r_phase, n_phase;
    logic [3:0]  r_ext_left, n_ext_left;
    logic [63:0] r_pay_left, n_pay_left;
    logic        r_final, n_final;
    logic [3:0]  r_msg_op, n_msg_op;
    logic [6:0]  r_frag_cnt, n_frag_cnt;
    logic        r_stuck, n_stuck;

    logic        done;
    logic        done_has;
    logic [63:0] pay_shift;
    logic [63:0] pay_dec;
    logic [3:0]  ext_dec;
    logic [6:0]  frag_inc;
    logic [7:0]  b;

    assign b         = i_data.rx_byte;
    assign pay_shift = {r_pay_left[55:0], b};
    assign pay_dec   = r_pay_left - 64'd1;
    assign ext_dec   = r_ext_left - 4'd1;
    assign frag_inc  = r_frag_cnt + 7'd1;

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_HEADER;
            r_ext_left <= '0;
            r_pay_left <= '0;
            r_final    <= 1'b0;
            r_msg_op   <= '0;
            r_frag_cnt <= '0;
            r_stuck    <= 1'b0;
        end else begin
            r_phase    <= n_phase;
            r_ext_left <= n_ext_left;
            r_pay_left <= n_pay_left;
            r_final    <= n_final;
            r_msg_op   <= n_msg_op;
            r_frag_cnt <= n_frag_cnt;
            r_stuck    <= n_stuck;
        end
    end

    // Next state and result for one input word
    always_comb begin
        n_phase     = r_phase;
        n_ext_left  = r_ext_left;
        n_pay_left  = r_pay_left;
        n_final     = r_final;
        n_msg_op    = r_msg_op;
        n_frag_cnt  = r_frag_cnt;
        n_stuck     = r_stuck;
        done        = 1'b0;
        done_has    = 1'b0;
        o_res_valid = 1'b0;
        o_res       = '0;

        if (i_step && !r_stuck) begin
            unique case (r_phase)
                PH_LENGTH: begin
                    if (b[7]) begin
                        n_stuck          = 1'b1;
                        o_res_valid      = 1'b1;
                        o_res.kind       = KIND_ERROR;
                        o_res.error_code = ERR_MASKED;
                    end else if (b[6:0] == LEN_EXT64) begin
                        n_pay_left = '0;
                        n_ext_left = EXT_BYTES64;
                        n_phase    = PH_EXT;
                    end else if (b[6:0] == LEN_EXT16) begin
                        n_pay_left = '0;
                        n_ext_left = EXT_BYTES16;
                        n_phase    = PH_EXT;
                    end else begin
                        n_pay_left = {57'd0, b[6:0]};
                        if (b[6:0] == 7'd0) begin
                            done = 1'b1;
                        end else begin
                            n_phase = PH_PAYLOAD;
                        end
                    end
                end
                PH_EXT: begin
                    n_pay_left = pay_shift;
                    n_ext_left = ext_dec;
                    if (ext_dec == 4'd0) begin
                        if (pay_shift == 64'd0) begin
                            done = 1'b1;
                        end else begin
                            n_phase = PH_PAYLOAD;
                        end
                    end
                end
                PH_PAYLOAD: begin
                    n_pay_left = pay_dec;
                    if (pay_dec == 64'd0) begin
                        done     = 1'b1;
                        done_has = 1'b1;
                    end else if (op_streams(r_msg_op)) begin
                        o_res_valid     = 1'b1;
                        o_res.kind      = KIND_BYTE;
                        o_res.has_byte  = 1'b1;
                        o_res.data_byte = b;
                        o_res.opcode    = r_msg_op;
                    end
                end
                default: begin
                    // header byte
                    if (b[6:4] != 3'd0) begin
                        n_stuck          = 1'b1;
                        o_res_valid      = 1'b1;
                        o_res.kind       = KIND_ERROR;
                        o_res.error_code = ERR_RSV;
                    end else begin
                        n_final = b[7];
                        if (r_frag_cnt == 7'd0) begin
                            n_msg_op = b[3:0];
                        end
                        n_ext_left = '0;
                        n_pay_left = '0;
                        n_phase    = PH_LENGTH;
                    end
                end
            endcase

            // End of frame
            if (done) begin
                n_phase    = PH_HEADER;
                n_pay_left = '0;
                if (!r_final) begin
                    n_frag_cnt = frag_inc;
                    if (frag_inc >= 7'(MAX_FRAGMENTS)) begin
                        n_stuck          = 1'b1;
                        o_res_valid      = 1'b1;
                        o_res.kind       = KIND_ERROR;
                        o_res.error_code = ERR_FRAGMENTS;
                    end else if (done_has && op_streams(r_msg_op)) begin
                        o_res_valid     = 1'b1;
                        o_res.kind      = KIND_BYTE;
                        o_res.has_byte  = 1'b1;
                        o_res.data_byte = b;
                        o_res.opcode    = r_msg_op;
                    end
                end else begin
                    n_frag_cnt = '0;
                    if (!op_known(r_msg_op)) begin
                        n_stuck          = 1'b1;
                        o_res_valid      = 1'b1;
                        o_res.kind       = KIND_ERROR;
                        o_res.error_code = ERR_UNKNOWN;
                    end else begin
                        o_res_valid  = 1'b1;
                        o_res.kind   = KIND_END;
                        o_res.opcode = r_msg_op;
                        o_res.last   = 1'b1;
                        if (done_has && op_streams(r_msg_op)) begin
                            o_res.has_byte  = 1'b1;
                            o_res.data_byte = b;
                        end
                        if (r_msg_op == OP_PING) begin
                            o_res.action = ACT_PONG;
                        end else if (r_msg_op == OP_CLOSE) begin
                            o_res.action = i_data.tx_closed ? ACT_ABORT : ACT_CLOSE;
                        end else begin
                            o_res.action = ACT_NONE;
                        end
                    end
                end
            end
        end
    end

endmodule

// ----- design/wsd_outbuf.sv -----
// Two-word result buffer that decouples the parser from output stalls.
// Depends on wsd_pkg.
module wsd_outbuf (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_wr,
    input  wsd_pkg::t_out i_wdata,
    output logic          o_room,
    output logic          o_valid,
    input  logic          i_ready,
    output wsd_pkg::t_out o_data
);
    import wsd_pkg::*;

    t_out       r_mem [2];
    logic       r_wr_ptr, r_rd_ptr;
    logic [1:0] r_count;
    logic       rd;

    assign o_room  = (r_count != 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_data  = r_mem[r_rd_ptr];
    assign rd      = o_valid && i_ready;

    // Storage
    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[r_wr_ptr] <= i_wdata;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= '0;
        end else begin
            if (i_wr) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (rd) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            r_count <= r_count + {1'b0, i_wr} - {1'b0, rd};
        end
    end

endmodule

// ----- design/websocket_frame_deframer.sv -----
// Websocket frame deframer top level: parser followed by a result buffer.
// A result is registered in the result buffer before it is offered.
// Throughput: one input word per cycle; the two-word result buffer sets
// the stall point, ready drops only while it holds two words.
// Reset: synchronous active-low, returns to expecting a header byte and
// clears the stuck-error flag and the buffer.
module websocket_frame_deframer #(
    parameter int MAX_FRAGMENTS = 64
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  wsd_pkg::t_in  i_data,
    output logic          o_valid,
    input  logic          i_ready,
    output wsd_pkg::t_out o_data
);
    import wsd_pkg::*;

    logic step;
    logic res_valid;
    t_out res;

    assign step = i_valid && o_ready;

    wsd_parse #(
        .MAX_FRAGMENTS(MAX_FRAGMENTS)
    ) u_parse (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_step     (step),
        .i_data     (i_data),
        .o_res_valid(res_valid),
        .o_res      (res)
    );

    wsd_outbuf u_outbuf (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_wr   (res_valid),
        .i_wdata(res),
        .o_room (o_ready),
        .o_valid(o_valid),
        .i_ready(i_ready),
        .o_data (o_data)
    );

endmodule
